[hw/rtl/gnf_pkg.sv]
// shared types and constants for the glyph to nibble framebuffer
`timescale 1ns / 1ps
`default_nettype none

package gnf_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned GX_W   = 8;
  localparam int unsigned GY_W   = 6;
  localparam int unsigned BI_W   = 5;
  localparam int unsigned GB_W   = 8;
  localparam int unsigned FV_W   = 8;
  localparam int unsigned RA_W   = 13;
  localparam int unsigned LVL_W  = 4;
  localparam int unsigned DATA_W = 8;

  // pixel column of a glyph byte, its byte column, its row
  localparam int unsigned COL_W = 9;
  localparam int unsigned BC_W  = 8;
  localparam int unsigned ROW_W = 7;
  // wide enough to hold the largest row or byte count
  localparam int unsigned CNT_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_GLYPH = 2'd0,
    OP_FILL  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef struct packed {
    logic latch;
    logic byte_rd;
    logic byte_wr;
    logic byte_next;
    logic fill_wr;
    logic fill_next;
    logic rd_issue;
  } gnf_cmd_t;

  typedef struct packed {
    logic glyph_ok;
    logic byte_last;
    logic fill_last;
  } gnf_stat_t;

endpackage

`default_nettype wire

[hw/rtl/gnf_ctrl.sv]
// controller state machine sequencing glyph, fill and read transactions
`timescale 1ns / 1ps
`default_nettype none

module gnf_ctrl import gnf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [OP_W-1:0] op_i,
  input  gnf_stat_t       stat_i,
  output gnf_cmd_t        cmd_o,
  output logic            busy_o,
  output logic            read_valid_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GRD  = 3'd1;
  localparam logic [2:0] S_GWR  = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_RRD  = 3'd4;
  localparam logic [2:0] S_ROUT = 3'd5;

  logic [2:0] state_q, state_d;
  op_e        op;

  assign op = op_e'(op_i);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          unique case (op)
            OP_GLYPH: state_d = S_GRD;
            OP_FILL:  state_d = S_FILL;
            OP_READ:  state_d = S_RRD;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_GRD: begin
        if (stat_i.glyph_ok) begin
          cmd_o.byte_rd = 1'b1;
          state_d       = S_GWR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_GWR: begin
        cmd_o.byte_wr = 1'b1;
        if (stat_i.byte_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.byte_next = 1'b1;
          state_d         = S_GRD;
        end
      end
      S_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (stat_i.fill_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.fill_next = 1'b1;
        end
      end
      S_RRD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_ROUT;
      end
      S_ROUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign read_valid_o = (state_q == S_ROUT);

  a_strobe_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_valid_o |-> $past(cmd_o.rd_issue))
    else $error("read strobe without a preceding read issue");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.byte_wr |-> $past(cmd_o.byte_rd))
    else $error("byte write without its read");

  a_read_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == OP_READ) |=> cmd_o.rd_issue)
    else $error("accepted read did not issue");

  a_fill_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.fill_wr && stat_i.fill_last) |=> !busy_o)
    else $error("fill did not finish after last byte");

endmodule

`default_nettype wire

[hw/rtl/gnf_dpath.sv]
// datapath with framebuffer memory, address generation and nibble merge
`timescale 1ns / 1ps
`default_nettype none

module gnf_dpath import gnf_pkg::*; #(
  parameter int unsigned ROW_BYTES = 128,
  parameter int unsigned FB_ROWS   = 64
) (
  input  logic              clk_i,
  input  gnf_cmd_t          cmd_i,
  output gnf_stat_t         stat_o,
  input  logic [GX_W-1:0]   glyph_x_i,
  input  logic [GY_W-1:0]   glyph_y_i,
  input  logic [BI_W-1:0]   byte_index_i,
  input  logic [GB_W-1:0]   glyph_byte_i,
  input  logic [FV_W-1:0]   fill_value_i,
  input  logic [RA_W-1:0]   read_addr_i,
  input  logic [LVL_W-1:0]  fg_level_i,
  input  logic [LVL_W-1:0]  bg_level_i,
  output logic [DATA_W-1:0] read_data_o
);

  localparam int unsigned STORE_BYTES = ROW_BYTES * FB_ROWS;
  localparam int unsigned AW          = $clog2(STORE_BYTES);
  localparam int unsigned WW          = AW + CNT_W;

  localparam logic [CNT_W-1:0] ROW_BYTES_L  = CNT_W'(ROW_BYTES);
  localparam logic [CNT_W-1:0] FB_ROWS_L    = CNT_W'(FB_ROWS);
  localparam logic [WW-1:0]    STORE_L      = WW'(STORE_BYTES);
  localparam logic [AW-1:0]    FILL_LAST_L  = AW'(STORE_BYTES - 1);

  // operand capture at transaction start
  logic [COL_W-1:0] base_in;
  logic [COL_W-1:0] end_in;
  logic [ROW_W-1:0] row_in;
  logic [WW-1:0]    row_base_w;
  logic [WW-1:0]    ra_w;

  logic [COL_W-1:0]  base_q;
  logic [BC_W-1:0]   bc_q;
  logic [BC_W-1:0]   last_bc_q;
  logic              row_ok_q;
  logic [AW-1:0]     row_base_q;
  logic [GB_W-1:0]   gb_q;
  logic [FV_W-1:0]   fv_q;
  logic [AW-1:0]     ra_q;
  logic              ra_ok_q;
  logic [AW-1:0]     fill_cnt_q;
  logic [DATA_W-1:0] rdata_q;

  logic [DATA_W-1:0] fb_mem_q [STORE_BYTES];

  assign base_in    = COL_W'(glyph_x_i) + COL_W'({byte_index_i[0], 3'b000});
  assign end_in     = base_in + COL_W'(7);
  assign row_in     = ROW_W'(glyph_y_i) + ROW_W'(byte_index_i[BI_W-1:1]);
  assign row_base_w = WW'(row_in) * WW'(ROW_BYTES);
  assign ra_w       = WW'(read_addr_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      base_q     <= base_in;
      bc_q       <= base_in[COL_W-1:1];
      last_bc_q  <= end_in[COL_W-1:1];
      row_ok_q   <= (CNT_W'(row_in) < FB_ROWS_L);
      row_base_q <= row_base_w[AW-1:0];
      gb_q       <= glyph_byte_i;
      fv_q       <= fill_value_i;
      ra_q       <= ra_w[AW-1:0];
      ra_ok_q    <= (ra_w < STORE_L);
      fill_cnt_q <= '0;
    end else begin
      if (cmd_i.byte_next) begin
        bc_q <= bc_q + BC_W'(1);
      end
      if (cmd_i.fill_next) begin
        fill_cnt_q <= fill_cnt_q + AW'(1);
      end
    end
  end

  // byte address within the current glyph row
  logic [WW-1:0] byte_addr_w;
  logic [AW-1:0] byte_addr;
  logic          bc_ok;

  assign byte_addr_w = WW'(row_base_q) + WW'(bc_q);
  assign byte_addr   = byte_addr_w[AW-1:0];
  assign bc_ok       = (CNT_W'(bc_q) < ROW_BYTES_L);

  assign stat_o.glyph_ok  = row_ok_q && bc_ok;
  assign stat_o.byte_last = (bc_q == last_bc_q);
  assign stat_o.fill_last = (fill_cnt_q == FILL_LAST_L);

  // nibble merge for the two pixels of the current byte
  logic [COL_W-1:0] d_hi, d_lo;
  logic             hit_hi, hit_lo;
  logic [LVL_W-1:0] lvl_hi, lvl_lo;
  logic [LVL_W-1:0] nib_hi, nib_lo;

  assign d_hi   = {bc_q, 1'b0} - base_q;
  assign d_lo   = {bc_q, 1'b1} - base_q;
  assign hit_hi = (d_hi < COL_W'(8));
  assign hit_lo = (d_lo < COL_W'(8));
  assign lvl_hi = gb_q[3'd7 - d_hi[2:0]] ? fg_level_i : bg_level_i;
  assign lvl_lo = gb_q[3'd7 - d_lo[2:0]] ? fg_level_i : bg_level_i;
  assign nib_hi = hit_hi ? lvl_hi : rdata_q[DATA_W-1:LVL_W];
  assign nib_lo = hit_lo ? lvl_lo : rdata_q[LVL_W-1:0];

  // single port framebuffer memory
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic              mem_re;
  logic [DATA_W-1:0] mem_wdata;

  always_comb begin
    if (cmd_i.fill_wr) begin
      mem_addr = fill_cnt_q;
    end else if (cmd_i.rd_issue) begin
      mem_addr = ra_q;
    end else begin
      mem_addr = byte_addr;
    end
  end

  assign mem_we    = cmd_i.fill_wr || cmd_i.byte_wr;
  assign mem_re    = cmd_i.byte_rd || cmd_i.rd_issue;
  assign mem_wdata = cmd_i.fill_wr ? fv_q : {nib_hi, nib_lo};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fb_mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= fb_mem_q[mem_addr];
    end
  end

  assign read_data_o = ra_ok_q ? rdata_q : '0;

endmodule

`default_nettype wire

[hw/rtl/glyph_to_nibble_framebuffer.sv]
// top level of the 4-bit gray glyph framebuffer with its register port
`timescale 1ns / 1ps
`default_nettype none

// Command port: a transaction is taken at a rising edge with start high and
// busy low. op selects a glyph byte write, a fill of the whole framebuffer or
// a byte read; op 3 is taken and does nothing.
// A glyph byte write read-modify-writes the four or five framebuffer bytes
// under its eight pixels, each through a read state and a write state on the
// single memory port; busy stays high until the last byte or a clipped byte.
// A fill writes one byte per cycle until every framebuffer byte is written.
// A read shows read_data_o with read_valid_o high for exactly one cycle, in
// the state after the read-issue state; busy then drops in the next cycle.
// The result is not held: the receiver takes it in that cycle.
// fg_level and bg_level sit at byte addresses 0 and 4 of the register port.
// The user writes them only while busy is low; the block does not enforce it.
// Reset sets fg_level to 15, bg_level to 0 and the sequencer idle; framebuffer
// contents are undefined until a fill, so a fill comes before the first read.
module glyph_to_nibble_framebuffer import gnf_pkg::*; #(
  parameter int unsigned ROW_BYTES = 128,
  parameter int unsigned FB_ROWS   = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   op_i,
  input  logic [GX_W-1:0]   glyph_x_i,
  input  logic [GY_W-1:0]   glyph_y_i,
  input  logic [BI_W-1:0]   byte_index_i,
  input  logic [GB_W-1:0]   glyph_byte_i,
  input  logic [FV_W-1:0]   fill_value_i,
  input  logic [RA_W-1:0]   read_addr_i,
  output logic              read_valid_o,
  output logic [DATA_W-1:0] read_data_o
);

  logic [LVL_W-1:0] fg_q, bg_q;
  logic             cfg_we;
  logic             reg_sel;

  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= LVL_W'(15);
      bg_q <= '0;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_FG:  fg_q <= pwdata[LVL_W-1:0];
        REG_BG:  bg_q <= pwdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FG:  prdata = 32'(fg_q);
      REG_BG:  prdata = 32'(bg_q);
      default: prdata = '0;
    endcase
  end

  gnf_cmd_t  cmd;
  gnf_stat_t stat;

  gnf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .op_i         (op_i),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .busy_o       (busy),
    .read_valid_o (read_valid_o)
  );

  gnf_dpath #(
    .ROW_BYTES (ROW_BYTES),
    .FB_ROWS   (FB_ROWS)
  ) u_dpath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .glyph_x_i    (glyph_x_i),
    .glyph_y_i    (glyph_y_i),
    .byte_index_i (byte_index_i),
    .glyph_byte_i (glyph_byte_i),
    .fill_value_i (fill_value_i),
    .read_addr_i  (read_addr_i),
    .fg_level_i   (fg_q),
    .bg_level_i   (bg_q),
    .read_data_o  (read_data_o)
  );

endmodule

`default_nettype wire
